/* hdl/rv64i_instruction_execute_assert.svh */
`ifndef RV64I_INSTRUCTION_EXECUTE_ASSERT_SVH
`define RV64I_INSTRUCTION_EXECUTE_ASSERT_SVH
// implication checked every clock, off in reset
`define RVX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RVX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* hdl/rvx_pkg.sv */
package rvx_pkg;
  localparam int MEM_BYTES_DEF = 4096;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM32  = 7'h1B;
  localparam logic [6:0] OP_REG32  = 7'h3B;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [3:0] ALU_ADD  = 4'd0;
  localparam logic [3:0] ALU_SUB  = 4'd1;
  localparam logic [3:0] ALU_SLL  = 4'd2;
  localparam logic [3:0] ALU_SLT  = 4'd3;
  localparam logic [3:0] ALU_SLTU = 4'd4;
  localparam logic [3:0] ALU_XOR  = 4'd5;
  localparam logic [3:0] ALU_SRL  = 4'd6;
  localparam logic [3:0] ALU_SRA  = 4'd7;
  localparam logic [3:0] ALU_OR   = 4'd8;
  localparam logic [3:0] ALU_AND  = 4'd9;
  localparam logic [3:0] ALU_EQ   = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    logic       word;
  } alu_ctl_t;
endpackage

/* hdl/rvx_ram.sv */
module rvx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/rvx_alu.sv */
module rvx_alu (
  input  rvx_pkg::alu_ctl_t ctl,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic [63:0]       y
);
  logic [63:0] r;
  logic [63:0] a32;
  logic [5:0]  sh;
  always_comb begin
    sh  = ctl.word ? {1'b0, b[4:0]} : b[5:0];
    a32 = ctl.op == rvx_pkg::ALU_SRA ? {{32{a[31]}}, a[31:0]} : {32'd0, a[31:0]};
    case (ctl.op)
      rvx_pkg::ALU_ADD:  r = a + b;
      rvx_pkg::ALU_SUB:  r = a - b;
      rvx_pkg::ALU_SLL:  r = a << sh;
      rvx_pkg::ALU_SLT:  r = {63'd0, $signed(a) < $signed(b)};
      rvx_pkg::ALU_SLTU: r = {63'd0, a < b};
      rvx_pkg::ALU_XOR:  r = a ^ b;
      rvx_pkg::ALU_SRL:  r = (ctl.word ? a32 : a) >> sh;
      rvx_pkg::ALU_SRA:  r = $signed(ctl.word ? a32 : a) >>> sh;
      rvx_pkg::ALU_OR:   r = a | b;
      rvx_pkg::ALU_AND:  r = a & b;
      rvx_pkg::ALU_EQ:   r = {63'd0, a == b};
      default:           r = '0;
    endcase
    y = ctl.word ? {{32{r[31]}}, r[31:0]} : r;
  end
endmodule

/* hdl/rv64i_instruction_execute.sv */
// channel | direction | handshake      | payload
// in_     | input     | valid / stall  | instruction_word
// out_    | output    | valid / stall  | next_pc, reg_written, dest_index, dest_value, halted, status
// cfg_    | input     | valid / ready  | start_address (64)
// Each op reads its source registers, executes in one shared ALU and writes back; loads
// and stores first move one byte at a time through the memory port. When halted the result
// follows the register read. The next transaction can be accepted as the result appears.
// After reset a clearing pass zeroes data memory; in_stall is high.
// A result held in the output register by out_stall stalls the input until it is taken.
// Halted (call depth zero): transactions return the pc without effect.
`include "rv64i_instruction_execute_assert.svh"
module rv64i_instruction_execute #(
  parameter int MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_next_pc,
  output logic        out_reg_written,
  output logic [4:0]  out_dest_index,
  output logic [63:0] out_dest_value,
  output logic        out_halted,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_start_address
);
  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_EXE = 3'd3,
                         S_MEM = 3'd4, S_LDW = 3'd5, S_WB = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic [63:0] pc_r, pc_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] ir_r, ir_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt, val_r, val_nxt, ea_r, ea_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        ovld_r, ovld_nxt;
  logic [63:0] onpc_r, onpc_nxt, oval_r, oval_nxt;
  logic        owr_r, owr_nxt, ohalt_r, ohalt_nxt, ostat_r, ostat_nxt;
  logic [4:0]  oidx_r, oidx_nxt;

  logic [63:0] rf_rdata, rf_wdata;
  logic [4:0]  rf_waddr, rf_raddr;
  logic        rf_we;
  logic        m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [7:0]  m_wdata, m_rdata;

  rvx_ram #(.WIDTH(64), .DEPTH(32)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata));
  rvx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata));

  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd, rs1, rs2;
  logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  rvx_pkg::alu_ctl_t actl;
  logic [63:0] alu_a, alu_b, alu_y;
  logic ok, wr, isld, isst;
  logic [3:0] nbytes;

  rvx_alu u_alu (.ctl(actl), .a(alu_a), .b(alu_b), .y(alu_y));

  assign op  = ir_r[6:0];
  assign rd  = ir_r[11:7];
  assign f3  = ir_r[14:12];
  assign rs1 = ir_r[19:15];
  assign rs2 = ir_r[24:20];
  assign f7  = ir_r[31:25];
  assign imm_i = {{52{ir_r[31]}}, ir_r[31:20]};
  assign imm_s = {{52{ir_r[31]}}, ir_r[31:25], ir_r[11:7]};
  assign imm_b = {{51{ir_r[31]}}, ir_r[31], ir_r[7], ir_r[30:25], ir_r[11:8], 1'b0};
  assign imm_j = {{43{ir_r[31]}}, ir_r[31], ir_r[19:12], ir_r[20], ir_r[30:21], 1'b0};
  assign imm_u = {{32{ir_r[31]}}, ir_r[31:12], 12'd0};
  assign isld  = op == rvx_pkg::OP_LOAD;
  assign isst  = op == rvx_pkg::OP_STORE;
  assign nbytes = 4'd1 << f3[1:0];

  // decode: legality, write flag and ALU setup for the execute step
  always_comb begin
    ok = 1'b1;
    wr = 1'b0;
    actl = '{op: rvx_pkg::ALU_ADD, word: 1'b0};
    alu_a = a_r;
    alu_b = b_r;
    case (op)
      rvx_pkg::OP_LUI: begin
        wr = 1'b1; alu_a = 64'd0; alu_b = imm_u;
      end
      rvx_pkg::OP_AUIPC: begin
        wr = 1'b1; alu_a = pc_r; alu_b = imm_u;
      end
      rvx_pkg::OP_JAL: begin
        wr = 1'b1; alu_a = pc_r; alu_b = imm_j;
      end
      rvx_pkg::OP_JALR: begin
        ok = f3 == 3'd0; wr = 1'b1; alu_b = imm_i;
      end
      rvx_pkg::OP_BRANCH: begin
        ok = f3 != 3'd2 && f3 != 3'd3;
        case (f3[2:1])
          2'd0:    actl.op = rvx_pkg::ALU_EQ;
          2'd2:    actl.op = rvx_pkg::ALU_SLT;
          default: actl.op = rvx_pkg::ALU_SLTU;
        endcase
      end
      rvx_pkg::OP_LOAD: begin
        ok = f3 != 3'd7; wr = 1'b1; alu_b = imm_i;
      end
      rvx_pkg::OP_STORE: begin
        ok = !f3[2]; alu_b = imm_s;
      end
      rvx_pkg::OP_IMM: begin
        wr = 1'b1; alu_b = imm_i;
        case (f3)
          3'd0: actl.op = rvx_pkg::ALU_ADD;
          3'd1: begin actl.op = rvx_pkg::ALU_SLL; ok = ir_r[31:26] == 6'd0; end
          3'd2: actl.op = rvx_pkg::ALU_SLT;
          3'd3: actl.op = rvx_pkg::ALU_SLTU;
          3'd4: actl.op = rvx_pkg::ALU_XOR;
          3'd5: begin
            actl.op = ir_r[30] ? rvx_pkg::ALU_SRA : rvx_pkg::ALU_SRL;
            ok = ir_r[31:26] == 6'd0 || ir_r[31:26] == 6'h10;
          end
          3'd6: actl.op = rvx_pkg::ALU_OR;
          default: actl.op = rvx_pkg::ALU_AND;
        endcase
      end
      rvx_pkg::OP_REG: begin
        wr = 1'b1;
        if (f7 == 7'h20) begin
          ok = f3 == 3'd0 || f3 == 3'd5;
          actl.op = f3 == 3'd0 ? rvx_pkg::ALU_SUB : rvx_pkg::ALU_SRA;
        end else begin
          ok = f7 == 7'd0;
          case (f3)
            3'd0: actl.op = rvx_pkg::ALU_ADD;
            3'd1: actl.op = rvx_pkg::ALU_SLL;
            3'd2: actl.op = rvx_pkg::ALU_SLT;
            3'd3: actl.op = rvx_pkg::ALU_SLTU;
            3'd4: actl.op = rvx_pkg::ALU_XOR;
            3'd5: actl.op = rvx_pkg::ALU_SRL;
            3'd6: actl.op = rvx_pkg::ALU_OR;
            default: actl.op = rvx_pkg::ALU_AND;
          endcase
        end
      end
      rvx_pkg::OP_IMM32, rvx_pkg::OP_REG32: begin
        wr = 1'b1; actl.word = 1'b1;
        if (op == rvx_pkg::OP_IMM32) alu_b = f3 == 3'd0 ? imm_i : {59'd0, rs2};
        if (f3 == 3'd0 && op == rvx_pkg::OP_IMM32) actl.op = rvx_pkg::ALU_ADD;
        else if (f3 == 3'd0 && f7 == 7'd0) actl.op = rvx_pkg::ALU_ADD;
        else if (f3 == 3'd0 && f7 == 7'h20) actl.op = rvx_pkg::ALU_SUB;
        else if (f3 == 3'd1 && f7 == 7'd0) actl.op = rvx_pkg::ALU_SLL;
        else if (f3 == 3'd5 && f7 == 7'd0) actl.op = rvx_pkg::ALU_SRL;
        else if (f3 == 3'd5 && f7 == 7'h20) actl.op = rvx_pkg::ALU_SRA;
        else ok = 1'b0;
      end
      rvx_pkg::OP_SYSTEM: wr = 1'b0;
      default: ok = 1'b0;
    endcase
  end

  logic take_in, take_out, jself, taken, brres;
  logic [63:0] ld_byte_ext;
  assign take_in  = in_valid && !in_stall;
  assign take_out = out_valid && !out_stall;
  assign in_stall = state_r != S_IDLE || (ovld_r && out_stall);
  assign cfg_ready = state_r == S_IDLE || state_r == S_CLR;
  assign out_valid = ovld_r;
  assign out_next_pc = onpc_r;
  assign out_reg_written = owr_r;
  assign out_dest_index = oidx_r;
  assign out_dest_value = oval_r;
  assign out_halted = ohalt_r;
  assign out_status = ostat_r;
  assign jself = ir_r[31:12] == 20'd0;
  assign brres = f3[0] ? !alu_y[0] : alu_y[0];
  assign ld_byte_ext = {56'd0, m_rdata};

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r; pc_nxt = pc_r; depth_nxt = depth_r;
    ir_nxt = ir_r; a_nxt = a_r; b_nxt = b_r; val_nxt = val_r; ea_nxt = ea_r;
    cnt_nxt = cnt_r; ovld_nxt = ovld_r; onpc_nxt = onpc_r; oval_nxt = oval_r;
    owr_nxt = owr_r; ohalt_nxt = ohalt_r; ostat_nxt = ostat_r; oidx_nxt = oidx_r;
    rf_we = 1'b0; rf_waddr = rd; rf_wdata = val_r; rf_raddr = rs1;
    m_we = 1'b0; m_waddr = ea_r[AW-1:0]; m_raddr = ea_r[AW-1:0];
    m_wdata = b_r[7:0]; taken = 1'b0;
    if (take_out) ovld_nxt = 1'b0;
    if (cfg_valid && cfg_ready) pc_nxt = cfg_start_address;
    case (state_r)
      S_CLR: begin
        m_we = 1'b1; m_waddr = clr_r[AW-1:0]; m_wdata = 8'd0;
        rf_we = clr_r < (AW+1)'(32); rf_waddr = clr_r[4:0]; rf_wdata = 64'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(MEM_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        rf_raddr = in_instruction_word[19:15];
        if (take_in) begin
          ir_nxt = in_instruction_word;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rf_raddr = rs2;
        state_nxt = S_EXE;
        if (depth_r == 16'd0) begin
          ovld_nxt = 1'b1; onpc_nxt = pc_r; owr_nxt = 1'b0; oidx_nxt = 5'd0;
          oval_nxt = 64'd0; ohalt_nxt = 1'b1; ostat_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
        a_nxt = rs1 == 5'd0 ? 64'd0 : rf_rdata;
      end
      S_EXE: begin
        if (cnt_r == 4'd0) begin
          b_nxt = rs2 == 5'd0 ? 64'd0 : rf_rdata;
          cnt_nxt = 4'd1;
        end else begin
          cnt_nxt = 4'd0;
          val_nxt = alu_y;
          ea_nxt = alu_y;
          if (op == rvx_pkg::OP_JAL || op == rvx_pkg::OP_JALR) val_nxt = pc_r + 64'd4;
          if (isld) val_nxt = 64'd0;
          if (!ok) begin
            ovld_nxt = 1'b1; onpc_nxt = pc_r; owr_nxt = 1'b0; oidx_nxt = 5'd0;
            oval_nxt = 64'd0; ohalt_nxt = 1'b0; ostat_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            case (op)
              rvx_pkg::OP_JAL: begin
                pc_nxt = alu_y;
                if (jself) depth_nxt = depth_r - 16'd1;
                else if (rd == 5'd1 && depth_r != 16'hFFFF) depth_nxt = depth_r + 16'd1;
              end
              rvx_pkg::OP_JALR: begin
                pc_nxt = {alu_y[63:1], 1'b0};
                if (rd == 5'd1) begin
                  if (depth_r != 16'hFFFF) depth_nxt = depth_r + 16'd1;
                end else if (rd == 5'd0 && rs1 == 5'd1) depth_nxt = depth_r - 16'd1;
              end
              rvx_pkg::OP_BRANCH: begin
                taken = brres;
                pc_nxt = pc_r + (taken ? imm_b : 64'd4);
              end
              default: pc_nxt = pc_r + 64'd4;
            endcase
            state_nxt = (isld || isst) ? S_MEM : S_WB;
          end
        end
      end
      S_MEM: begin
        if (isst) begin
          m_we = 1'b1;
          b_nxt = b_r >> 8;
          ea_nxt = ea_r + 64'd1;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r + 4'd1 == nbytes) begin
            cnt_nxt = 4'd0; state_nxt = S_WB;
          end
        end else begin
          state_nxt = S_LDW;
        end
      end
      S_LDW: begin
        val_nxt = val_r | (ld_byte_ext << {cnt_r[2:0], 3'd0});
        ea_nxt = ea_r + 64'd1;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = S_MEM;
        if (cnt_r + 4'd1 == nbytes) begin
          cnt_nxt = 4'd0; state_nxt = S_WB;
          if (!f3[2]) begin
            case (f3[1:0])
              2'd0: val_nxt = {{56{m_rdata[7]}}, m_rdata};
              2'd1: val_nxt = {{48{m_rdata[7]}}, m_rdata, val_r[7:0]};
              2'd2: val_nxt = {{32{m_rdata[7]}}, m_rdata, val_r[23:0]};
              default: val_nxt = {m_rdata, val_r[55:0]};
            endcase
          end
        end
      end
      S_WB: begin
        rf_we = wr && rd != 5'd0;
        ovld_nxt = 1'b1; onpc_nxt = pc_r; owr_nxt = rf_we;
        oidx_nxt = rf_we ? rd : 5'd0; oval_nxt = rf_we ? val_r : 64'd0;
        ohalt_nxt = depth_r == 16'd0; ostat_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; pc_r <= 64'd0; depth_r <= 16'd1;
      cnt_r <= 4'd0; ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; pc_r <= pc_nxt; depth_r <= depth_nxt;
      cnt_r <= cnt_nxt; ovld_r <= ovld_nxt;
    end
    ir_r <= ir_nxt; a_r <= a_nxt; b_r <= b_nxt; val_r <= val_nxt; ea_r <= ea_nxt;
    onpc_r <= onpc_nxt; oval_r <= oval_nxt; owr_r <= owr_nxt; ohalt_r <= ohalt_nxt;
    ostat_r <= ostat_nxt; oidx_r <= oidx_nxt;
  end

  `RVX_ASSERT_IMP(a_x0_quiet, out_valid && out_reg_written, out_dest_index != 5'd0,
                  "x0 reported as written")
  `RVX_ASSERT_IMP(a_bad_nowr, out_valid && out_status, !out_reg_written,
                  "unsupported encoding wrote a register")
  `RVX_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_next_pc),
                  "held result changed")
endmodule
